// ===== hdl/spq_pkg.sv =====
// Shared constants, action codes and control types for the sorted priority queue.
`timescale 1ns / 1ps

package spq_pkg;

  // Default sizes handed to the top-level parameters
  localparam int DEPTH_DEF         = 16;
  localparam int KEY_WIDTH_DEF     = 8;
  localparam int PAYLOAD_WIDTH_DEF = 32;

  // Action field
  localparam int ACT_W = 3;

  localparam logic [ACT_W-1:0] ACT_INSERT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 3'd1;
  localparam logic [ACT_W-1:0] ACT_COUNT  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACT_W-1:0] ACT_CLEAR  = 3'd4;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;    // capture the incoming request
    logic commit;  // apply the request to the list and load the result register
  } spq_cmd_t;

endpackage

// ===== hdl/spq_ctrl.sv =====
// Controller: sequences one request at a time and owns the result handshake.
`timescale 1ns / 1ps

module spq_ctrl
  import spq_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  output logic     in_tready,
  output logic     out_tvalid,
  input  logic     out_tready,
  output spq_cmd_t cmd
);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic out_free;

  assign out_free   = !out_valid_r || out_tready;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  assign cmd.load   = in_tvalid && in_tready;
  assign cmd.commit = (state_r == S_EXEC) && out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.load) state_nxt = S_EXEC;
      S_EXEC: if (cmd.commit) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== hdl/spq_dp.sv =====
// Datapath: request registers, sorted shift array of entries, fill count and result register.
`timescale 1ns / 1ps

module spq_dp
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  parameter int CNT_W         = $clog2(DEPTH + 1)
)
(
  input  logic                     clk,
  input  logic                     rst_n,
  input  spq_cmd_t                 cmd,
  input  logic [ACT_W-1:0]         in_action,
  input  logic [KEY_WIDTH-1:0]     in_severity,
  input  logic [PAYLOAD_WIDTH-1:0] in_payload,
  input  logic [CNT_W-1:0]         in_position,
  output logic                     res_ok,
  output logic [KEY_WIDTH-1:0]     res_severity,
  output logic [PAYLOAD_WIDTH-1:0] res_payload,
  output logic [CNT_W-1:0]         res_count
);

  localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  // Captured request
  logic [ACT_W-1:0]         act_r;
  logic [KEY_WIDTH-1:0]     key_r;
  logic [PAYLOAD_WIDTH-1:0] data_r;
  logic [CNT_W-1:0]         pos_r;

  // Entry array, cell 0 is the head
  logic [KEY_WIDTH-1:0]     key_cell_r   [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] data_cell_r  [DEPTH];
  logic [KEY_WIDTH-1:0]     key_cell_nxt [DEPTH];
  logic [PAYLOAD_WIDTH-1:0] data_cell_nxt[DEPTH];

  logic [CNT_W-1:0] fill_r, fill_nxt;

  // Result register
  logic                     ok_r;
  logic [KEY_WIDTH-1:0]     rkey_r;
  logic [PAYLOAD_WIDTH-1:0] rdata_r;
  logic [CNT_W-1:0]         rcnt_r;

  logic                     ok_nxt;
  logic [KEY_WIDTH-1:0]     rkey_nxt;
  logic [PAYLOAD_WIDTH-1:0] rdata_nxt;

  logic             full, empty, pos_ok;
  logic             do_ins, do_pop;
  logic [CNT_W-1:0] pos_m1;
  logic [IDX_W-1:0] rd_idx;
  logic [DEPTH-1:0] stay;  // valid cell whose key is <= new key: sits ahead of the new entry

  assign full   = (fill_r == CNT_W'(DEPTH));
  assign empty  = (fill_r == '0);
  assign pos_ok = (pos_r != '0) && (pos_r <= fill_r);
  assign pos_m1 = pos_r - CNT_W'(1);
  assign rd_idx = pos_m1[IDX_W-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r  <= in_action;
      key_r  <= in_severity;
      data_r <= in_payload;
      pos_r  <= in_position;
    end
  end

  always_comb begin
    ok_nxt    = 1'b0;
    rkey_nxt  = '0;
    rdata_nxt = '0;
    fill_nxt  = fill_r;
    do_ins    = 1'b0;
    do_pop    = 1'b0;
    unique case (act_r)
      ACT_INSERT: begin
        if (!full) begin
          do_ins   = 1'b1;
          fill_nxt = fill_r + CNT_W'(1);
          ok_nxt   = 1'b1;
        end
      end
      ACT_POP: begin
        if (!empty) begin
          do_pop    = 1'b1;
          rkey_nxt  = key_cell_r[0];
          rdata_nxt = data_cell_r[0];
          fill_nxt  = fill_r - CNT_W'(1);
          ok_nxt    = 1'b1;
        end
      end
      ACT_COUNT: ok_nxt = 1'b1;
      ACT_READ: begin
        if (pos_ok) begin
          rkey_nxt  = key_cell_r[rd_idx];
          rdata_nxt = data_cell_r[rd_idx];
          ok_nxt    = 1'b1;
        end
      end
      ACT_CLEAR: begin
        if (!empty) begin
          fill_nxt = '0;
          ok_nxt   = 1'b1;
        end
      end
      default: ;  // unused codes leave the list alone and fail
    endcase
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign stay[i] = (CNT_W'(i) < fill_r) && (key_cell_r[i] <= key_r);

    always_comb begin
      key_cell_nxt[i]  = key_cell_r[i];
      data_cell_nxt[i] = data_cell_r[i];
      if (do_ins && !stay[i]) begin
        if (i == 0) begin
          key_cell_nxt[i]  = key_r;
          data_cell_nxt[i] = data_r;
        end else if (stay[(i == 0) ? 0 : i - 1]) begin
          key_cell_nxt[i]  = key_r;
          data_cell_nxt[i] = data_r;
        end else begin
          key_cell_nxt[i]  = key_cell_r[(i == 0) ? 0 : i - 1];
          data_cell_nxt[i] = data_cell_r[(i == 0) ? 0 : i - 1];
        end
      end else if (do_pop && (i < DEPTH - 1)) begin
        key_cell_nxt[i]  = key_cell_r[(i < DEPTH - 1) ? i + 1 : i];
        data_cell_nxt[i] = data_cell_r[(i < DEPTH - 1) ? i + 1 : i];
      end
    end

    always_ff @(posedge clk) begin
      if (cmd.commit) begin
        key_cell_r[i]  <= key_cell_nxt[i];
        data_cell_r[i] <= data_cell_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
    end else if (cmd.commit) begin
      fill_r <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      ok_r    <= ok_nxt;
      rkey_r  <= rkey_nxt;
      rdata_r <= rdata_nxt;
      rcnt_r  <= fill_nxt;
    end
  end

  assign res_ok       = ok_r;
  assign res_severity = rkey_r;
  assign res_payload  = rdata_r;
  assign res_count    = rcnt_r;

endmodule

// ===== hdl/sorted_priority_queue.sv =====
// Top level of the sorted priority queue: stream ports, controller and datapath.
`timescale 1ns / 1ps
//
// Bounded priority queue kept sorted by ascending severity, DEPTH entries.
// Input stream: in_tuser carries the action (insert, pop head, report count,
// read at 1-based position, clear); in_tdata carries severity, payload and
// position. Every request yields exactly one transfer on the output stream:
// out_tuser is the ok flag, out_tdata holds the popped or read entry (zero
// otherwise) and the entry count after the action.
// A captured request moves the controller to its execute state; out_tvalid
// rises when that state commits the request, once the output is free.
// The controller handles one request at a time and takes no new one until
// the last is committed (capture, then a compare-and-shift across all cells).
// Insert compares the new key against every stored cell in parallel and
// shifts the tail by one cell; pop shifts everything toward the head.
// A stalled output (out_tready low) holds the result register; a captured
// request then waits in the execute state and in_tready stays low.
// Reset (rst_n low, synchronous) empties the queue and drops any pending
// result; entry cells are not cleared, only the fill count.
//
module sorted_priority_queue
  import spq_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEF,
  parameter int KEY_WIDTH     = KEY_WIDTH_DEF,
  parameter int PAYLOAD_WIDTH = PAYLOAD_WIDTH_DEF,
  parameter int CNT_W         = $clog2(DEPTH + 1),
  parameter int TDATA_W       = ((KEY_WIDTH + PAYLOAD_WIDTH + CNT_W + 7) / 8) * 8
)
(
  input  logic               clk,
  input  logic               rst_n,
  // input request stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [TDATA_W-1:0] in_tdata,   // severity, payload, position (low to high)
  input  logic [ACT_W-1:0]   in_tuser,   // action
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [TDATA_W-1:0] out_tdata,  // out_severity, out_payload, count (low to high)
  output logic               out_tuser   // ok
);

  localparam int PAY_LO = KEY_WIDTH;
  localparam int POS_LO = KEY_WIDTH + PAYLOAD_WIDTH;
  localparam int FLD_W  = KEY_WIDTH + PAYLOAD_WIDTH + CNT_W;

  spq_cmd_t cmd;

  logic                     res_ok;
  logic [KEY_WIDTH-1:0]     res_severity;
  logic [PAYLOAD_WIDTH-1:0] res_payload;
  logic [CNT_W-1:0]         res_count;

  spq_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  spq_dp #(
    .DEPTH         (DEPTH),
    .KEY_WIDTH     (KEY_WIDTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH),
    .CNT_W         (CNT_W)
  ) u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_action    (in_tuser),
    .in_severity  (in_tdata[KEY_WIDTH-1:0]),
    .in_payload   (in_tdata[POS_LO-1:PAY_LO]),
    .in_position  (in_tdata[FLD_W-1:POS_LO]),
    .res_ok       (res_ok),
    .res_severity (res_severity),
    .res_payload  (res_payload),
    .res_count    (res_count)
  );

  // pack result fields, zero-filled up to the byte boundary
  assign out_tdata = TDATA_W'({res_count, res_payload, res_severity});
  assign out_tuser = res_ok;

endmodule
